// ===== rtl/nsr_pkg.sv =====
// Shared types and constants for the Newton square root block.
// Used by nsr_divider, nsr_cfg and newton_square_root; depends on nothing.
`default_nettype none

package nsr_pkg;

    localparam int unsigned IN_W   = 32;
    localparam int unsigned ROOT_W = 25;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned DVD_W  = IN_W + FRAC_W;
    localparam int unsigned DVS_W  = IN_W;
    localparam int unsigned THR_W  = 17;
    localparam int unsigned PREC_W = 4;

    localparam logic [IN_W-1:0]   ONE_Q16     = 32'h0001_0000;
    localparam logic [ROOT_W-1:0] ROOT_NEG    = 25'h1FF_0000;
    localparam logic [PREC_W-1:0] PREC_RESET  = 4'd3;
    localparam logic [1:0]        REG_PREC    = 2'd0;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [THR_W-1:0] thresh(input logic [PREC_W-1:0] digits);
        logic [THR_W-1:0] t;
        unique case (digits)
            4'd0:    t = 17'd65536;
            4'd1:    t = 17'd6554;
            4'd2:    t = 17'd655;
            4'd3:    t = 17'd66;
            4'd4:    t = 17'd7;
            default: t = 17'd1;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/newton_square_root.sv =====
// Newton-Raphson square root of a signed Q15.16 operand, result in signed Q8.16.
// Depends on nsr_pkg, nsr_divider and nsr_cfg.
//
// Usage:
//   s_tdata[31:0] carries value_in; a beat is taken when s_tvalid and s_tready are high.
//   m_tdata[24:0] carries root_out (upper bits zero), m_tuser[0] carries limit_hit.
//   The APB port holds precision_digits at address 0; write it only while idle.
// Timing:
//   A negative, zero or 1.0 operand skips the divider and goes straight to ST_OUT.
//   Otherwise each Newton step loads the shared restoring divider, which
//   produces its 48 quotient bits one a cycle; the update sum is then registered
//   and the stop compare follows. The step count is data dependent,
//   at most MAX_ITERATIONS.
//   One item is in work at a time; s_tready is high only while the sequencer idles.
//   The output register holds a finished result while m_tready is low and a
//   new item may be accepted meanwhile; the sequencer waits to hand over its
//   next result until the output register is free.
// Reset: aresetn clears the sequencer and output valid and sets precision_digits to 3.
`default_nettype none

module newton_square_root #(
    parameter int unsigned MAX_ITERATIONS = 40
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [24:0] root_out, [31:25] zero
    output logic [0:0]       m_tuser,   // [0] limit_hit
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned CNT_W = $clog2(MAX_ITERATIONS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    logic [2:0]                  state_reg;
    logic [nsr_pkg::IN_W-1:0]    est_reg;
    logic [nsr_pkg::IN_W-1:0]    opnd_reg;
    logic [nsr_pkg::DVD_W-1:0]   nxt_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic                        start_reg;
    logic                        start_next;
    logic [nsr_pkg::ROOT_W-1:0]  res_root_reg;
    logic                        res_hit_reg;
    logic                        m_tvalid_reg;
    logic [nsr_pkg::ROOT_W-1:0]  m_root_reg;
    logic                        m_hit_reg;

    logic [nsr_pkg::PREC_W-1:0]  prec;
    logic [nsr_pkg::THR_W-1:0]   thr;
    nsr_pkg::div_req_t           div_req;
    nsr_pkg::div_rsp_t           div_rsp;

    logic                        s_fire;
    logic                        direct_in;
    logic                        out_free;
    logic [nsr_pkg::DVD_W:0]     sum;
    logic [nsr_pkg::DVD_W-1:0]   est_ext;
    logic [nsr_pkg::DVD_W-1:0]   diff;
    logic                        converged;

    nsr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .prec    (prec)
    );

    assign div_req = {start_reg, opnd_reg, {nsr_pkg::FRAC_W{1'b0}}, est_reg};

    nsr_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign thr       = nsr_pkg::thresh(prec);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign direct_in = s_tdata[31] || s_tdata == '0 || s_tdata == nsr_pkg::ONE_Q16;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign est_ext   = {{nsr_pkg::FRAC_W{1'b0}}, est_reg};
    assign sum       = {1'b0, est_ext} + {1'b0, div_rsp.quotient};
    assign diff      = (nxt_reg > est_ext) ? (nxt_reg - est_ext) : (est_ext - nxt_reg);
    assign converged = diff < {{(nsr_pkg::DVD_W - nsr_pkg::THR_W){1'b0}}, thr};
    assign cnt_next  = cnt_reg + 1'b1;
    assign start_next = (state_reg == ST_IDLE && s_fire && !direct_in)
                     || (state_reg == ST_CHK && !converged
                         && cnt_next != CNT_W'(MAX_ITERATIONS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            start_reg <= start_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (direct_in) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_DIV;
                            cnt_reg   <= '0;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (converged) begin
                        state_reg <= ST_OUT;
                    end else begin
                        cnt_reg <= cnt_next;
                        if (cnt_next == CNT_W'(MAX_ITERATIONS)) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_fire) begin
            est_reg  <= s_tdata;
            opnd_reg <= s_tdata;
            res_hit_reg <= 1'b0;
            if (s_tdata[31]) begin
                res_root_reg <= nsr_pkg::ROOT_NEG;
            end else begin
                res_root_reg <= s_tdata[nsr_pkg::ROOT_W-1:0];
            end
        end
        if (state_reg == ST_DIV && div_rsp.done) begin
            nxt_reg <= sum[nsr_pkg::DVD_W:1];
        end
        if (state_reg == ST_CHK) begin
            if (converged) begin
                res_root_reg <= est_reg[nsr_pkg::ROOT_W-1:0];
                res_hit_reg  <= 1'b0;
            end else begin
                est_reg      <= nxt_reg[nsr_pkg::IN_W-1:0];
                res_root_reg <= nxt_reg[nsr_pkg::ROOT_W-1:0];
                res_hit_reg  <= 1'b1;
            end
        end
        if (state_reg == ST_OUT && out_free) begin
            m_root_reg <= res_root_reg;
            m_hit_reg  <= res_hit_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {{(32 - nsr_pkg::ROOT_W){1'b0}}, m_root_reg};
    assign m_tuser[0] = m_hit_reg;

    a_div_to_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_rsp.done) |=> (state_reg == ST_CHK))
        else $error("divider completion did not advance to the stop check");

    a_neg_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tdata[31]) |=> (state_reg == ST_OUT && res_root_reg == nsr_pkg::ROOT_NEG))
        else $error("negative operand did not yield -1.0");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ITERATIONS))
        else $error("step count beyond iteration cap");

    a_cap_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> !m_tdata[nsr_pkg::ROOT_W-1])
        else $error("capped result carries a negative root");

    a_start_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> (state_reg == ST_DIV))
        else $error("divider started outside the divide state");

endmodule

`default_nettype wire

// ===== rtl/nsr_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Uses nsr_pkg request/response structs; division by zero yields all ones.
`default_nettype none

module nsr_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire nsr_pkg::div_req_t req,
    output nsr_pkg::div_rsp_t      rsp
);

    localparam int unsigned CNT_W = $clog2(nsr_pkg::DVD_W);

    logic [nsr_pkg::DVS_W-1:0] rem_reg;
    logic [nsr_pkg::DVD_W-1:0] quo_reg;
    logic [nsr_pkg::DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [nsr_pkg::DVS_W:0]   trial;
    logic [nsr_pkg::DVS_W+1:0] diff;
    logic                      ge;
    logic                      last_bit;

    assign trial    = {rem_reg, quo_reg[nsr_pkg::DVD_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, dvs_reg};
    assign ge       = ~diff[nsr_pkg::DVS_W+1];
    assign last_bit = (cnt_reg == CNT_W'(nsr_pkg::DVD_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !req.start && last_bit;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_bit) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[nsr_pkg::DVS_W-1:0] : trial[nsr_pkg::DVS_W-1:0];
            quo_reg <= {quo_reg[nsr_pkg::DVD_W-2:0], ge};
        end
    end

    assign rsp = {done_reg, quo_reg};

endmodule

`default_nettype wire

// ===== rtl/nsr_cfg.sv =====
// APB register file holding the precision_digits setting.
// Uses nsr_pkg for the register index and reset value.
`default_nettype none

module nsr_cfg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [3:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [nsr_pkg::PREC_W-1:0]      prec
);

    logic [nsr_pkg::PREC_W-1:0] prec_reg;
    logic                       hit_prec;

    assign hit_prec = (paddr[3:2] == nsr_pkg::REG_PREC) && (paddr[1:0] == 2'b00);
    assign pready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prec_reg <= nsr_pkg::PREC_RESET;
        end else if (psel && penable && pwrite && hit_prec) begin
            prec_reg <= pwdata[nsr_pkg::PREC_W-1:0];
        end
    end

    assign prdata = hit_prec ? {{(32 - nsr_pkg::PREC_W){1'b0}}, prec_reg} : 32'h0;
    assign prec   = prec_reg;

endmodule

`default_nettype wire
